// ===== hw/rtl/spr_pkg.sv =====
package spr_pkg;

    localparam int CTRL_W  = 8;
    localparam int COUNT_W = 16;
    localparam int ANGLE_W = 16;

    localparam int BIT_RELAY1   = 0;
    localparam int BIT_RELAY2   = 1;
    localparam int BIT_MOTOR_ON = 2;
    localparam int BIT_REVERSE  = 3;

    localparam logic [CTRL_W-1:0]  END_MASK    = 8'hF3;
    localparam logic [ANGLE_W-1:0] ANGLE_RESET = 16'(2 * 360);

    // angle*5 stays below 2^19; 932068 = ceil(2^23 / 9) divides exactly in that range
    localparam int                 SCALED_W    = 19;
    localparam int                 RECIP_W     = 20;
    localparam int                 PROD_W      = SCALED_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV9_RECIP  = 20'd932068;
    localparam int                 DIV9_SHIFT  = 23;
    localparam logic [COUNT_W-1:0] COUNT_BIAS  = 16'd4;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef struct packed {
        logic              relay_one;
        logic              relay_two;
        logic              motor_enable;
        logic              motor_direction;
        logic              step_line;
        logic [CTRL_W-1:0] control_value;
        logic              done_report;
    } t_result;

    function automatic logic [COUNT_W-1:0] pulse_count(input logic [ANGLE_W-1:0] angle);
        logic [SCALED_W-1:0] scaled;
        logic [PROD_W-1:0]   prod;
        scaled = SCALED_W'(angle) * SCALED_W'(5);
        prod   = PROD_W'(scaled) * PROD_W'(DIV9_RECIP);
        return prod[DIV9_SHIFT +: COUNT_W] + COUNT_BIAS;
    endfunction

endpackage

// ===== hw/rtl/spr_cmd_if.sv =====
interface spr_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] bit_mask;

    modport source (output valid, output opcode, output bit_mask, input ready);
    modport sink   (input valid, input opcode, input bit_mask, output ready);
endinterface

// ===== hw/rtl/spr_res_if.sv =====
interface spr_res_if;
    logic       valid;
    logic       ready;
    logic       relay_one;
    logic       relay_two;
    logic       motor_enable;
    logic       motor_direction;
    logic       step_line;
    logic [7:0] control_value;
    logic       done_report;

    modport source (
        output valid, output relay_one, output relay_two, output motor_enable,
        output motor_direction, output step_line, output control_value,
        output done_report, input ready
    );
    modport sink (
        input valid, input relay_one, input relay_two, input motor_enable,
        input motor_direction, input step_line, input control_value,
        input done_report, output ready
    );
endinterface

// ===== hw/rtl/spr_cfg.sv =====
module spr_cfg
    import spr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [ANGLE_W-1:0] i_cfg_wdata,
    output logic [COUNT_W-1:0] o_pulse_load
);

    logic [COUNT_W-1:0] r_pulse_load;

    // keep the derived pulse count rather than the raw angle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_load <= pulse_count(ANGLE_RESET);
        end else if (i_cfg_we) begin
            r_pulse_load <= pulse_count(i_cfg_wdata);
        end
    end

    assign o_pulse_load = r_pulse_load;

endmodule

// ===== hw/rtl/spr_core.sv =====
module spr_core
    import spr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [1:0]         i_op,
    input  logic [CTRL_W-1:0]  i_mask,
    input  logic [COUNT_W-1:0] i_pulse_load,
    output t_result            o_result
);

    logic [CTRL_W-1:0]  r_ctrl,    n_ctrl;
    logic [COUNT_W-1:0] r_pulses,  n_pulses;
    logic               r_running, n_running;
    logic               r_timer,   n_timer;
    logic               r_phase,   n_phase;
    logic               r_step,    n_step;
    logic               r_enable,  n_enable;
    logic               r_dir,     n_dir;
    logic               n_done;
    logic               write_op;
    logic [CTRL_W-1:0]  ctrl_w;

    always_comb begin
        n_ctrl    = r_ctrl;
        n_pulses  = r_pulses;
        n_running = r_running;
        n_timer   = r_timer;
        n_phase   = r_phase;
        n_step    = r_step;
        n_enable  = r_enable;
        n_dir     = r_dir;
        n_done    = 1'b0;
        write_op  = 1'b0;
        ctrl_w    = r_ctrl;

        unique case (t_op'(i_op))
            OP_SET: begin
                write_op = 1'b1;
                ctrl_w   = r_ctrl | i_mask;
            end
            OP_CLEAR: begin
                write_op = 1'b1;
                ctrl_w   = r_ctrl & ~i_mask;
            end
            OP_TICK: begin
                if (r_timer) begin
                    if (r_pulses != '0) begin
                        n_step  = ~r_phase;
                        n_phase = ~r_phase;
                        if (r_phase) begin
                            n_pulses = r_pulses - COUNT_W'(1);
                        end
                    end else if (r_running) begin
                        n_ctrl    = r_ctrl & END_MASK;
                        n_running = 1'b0;
                        n_timer   = 1'b0;
                        n_done    = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (write_op) begin
            n_ctrl = ctrl_w;
            if (ctrl_w[BIT_MOTOR_ON]) begin
                n_enable  = 1'b1;
                n_dir     = ctrl_w[BIT_REVERSE];
                n_pulses  = i_pulse_load;
                n_running = 1'b1;
                n_timer   = 1'b1;
            end else begin
                n_enable  = 1'b0;
                n_dir     = 1'b0;
                n_running = 1'b0;
                n_pulses  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl    <= '0;
            r_pulses  <= '0;
            r_running <= 1'b0;
            r_timer   <= 1'b0;
            r_phase   <= 1'b0;
            r_step    <= 1'b0;
            r_enable  <= 1'b0;
            r_dir     <= 1'b0;
        end else if (i_fire) begin
            r_ctrl    <= n_ctrl;
            r_pulses  <= n_pulses;
            r_running <= n_running;
            r_timer   <= n_timer;
            r_phase   <= n_phase;
            r_step    <= n_step;
            r_enable  <= n_enable;
            r_dir     <= n_dir;
        end
    end

    always_comb begin
        o_result.relay_one       = n_ctrl[BIT_RELAY1];
        o_result.relay_two       = n_ctrl[BIT_RELAY2];
        o_result.motor_enable    = n_enable;
        o_result.motor_direction = n_dir;
        o_result.step_line       = n_step;
        o_result.control_value   = n_ctrl;
        o_result.done_report     = n_done;
    end

endmodule

// ===== hw/rtl/stepper_pulse_relay_control.sv =====
// Channel   Dir  Handshake      Word
// i_cmd     in   valid/ready    opcode[1:0], bit_mask[7:0]
// o_res     out  valid/ready    relays, motor lines, step line, control_value[7:0], done_report
// cfg       in   i_cfg_we       i_cfg_wdata[15:0] = step angle
//
// One word per cycle sustained while results are taken; an accepted word passes the input register
// and then the result register, where its result turns valid; a stalled result holds it back.
// Input register -> state update -> result register; the result handshake sets the pace.
// Reset (synchronous, active low) empties both stages; step angle returns to 720.
// A stalled result holds its stage; the input stage still takes a word while empty.
module stepper_pulse_relay_control
    import spr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    spr_cmd_if.sink            i_cmd,
    spr_res_if.source          o_res,
    input  logic               i_cfg_we,
    input  logic [ANGLE_W-1:0] i_cfg_wdata
);

    logic               r_in_valid;
    logic [1:0]         r_op;
    logic [CTRL_W-1:0]  r_mask;
    logic               r_out_valid;
    t_result            r_res;
    t_result            core_res;
    logic [COUNT_W-1:0] pulse_load;
    logic               out_load;
    logic               fire;
    logic               in_ready;

    assign out_load    = !r_out_valid || o_res.ready;
    assign fire        = r_in_valid && out_load;
    assign in_ready    = !r_in_valid || out_load;
    assign i_cmd.ready = in_ready;

    spr_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pulse_load (pulse_load)
    );

    spr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_op         (r_op),
        .i_mask       (r_mask),
        .i_pulse_load (pulse_load),
        .o_result     (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && in_ready) begin
            r_op   <= i_cmd.opcode;
            r_mask <= i_cmd.bit_mask;
        end
        if (fire) begin
            r_res <= core_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.relay_one       = r_res.relay_one;
    assign o_res.relay_two       = r_res.relay_two;
    assign o_res.motor_enable    = r_res.motor_enable;
    assign o_res.motor_direction = r_res.motor_direction;
    assign o_res.step_line       = r_res.step_line;
    assign o_res.control_value   = r_res.control_value;
    assign o_res.done_report     = r_res.done_report;

endmodule

// ===== hw/rtl/spr_checker.sv =====
module spr_checker
    import spr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic              i_relay_one,
    input logic              i_relay_two,
    input logic              i_motor_enable,
    input logic              i_motor_direction,
    input logic              i_step_line,
    input logic [CTRL_W-1:0] i_control_value,
    input logic              i_done_report
);

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_control_value)
            && $stable(i_step_line) && $stable(i_done_report))
        else $error("stalled result word changed");

    a_relays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_relay_one == i_control_value[BIT_RELAY1]
            && i_relay_two == i_control_value[BIT_RELAY2])
        else $error("relay lines disagree with control value");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_done_report |-> !i_control_value[BIT_MOTOR_ON]
            && !i_control_value[BIT_REVERSE])
        else $error("end of move left motor bits set");

    a_dir_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_motor_direction |-> i_motor_enable)
        else $error("direction set with motor disabled");

endmodule

bind stepper_pulse_relay_control spr_checker u_spr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_relay_one       (o_res.relay_one),
    .i_relay_two       (o_res.relay_two),
    .i_motor_enable    (o_res.motor_enable),
    .i_motor_direction (o_res.motor_direction),
    .i_step_line       (o_res.step_line),
    .i_control_value   (o_res.control_value),
    .i_done_report     (o_res.done_report)
);

// ===== verif/stepper_pulse_relay_control_tb.sv =====
module stepper_pulse_relay_control_tb;
    import spr_pkg::*;

    localparam logic [1:0]        OP_SPARE   = 2'd3;
    localparam logic [CTRL_W-1:0] MOTOR_MASK = CTRL_W'(1 << BIT_MOTOR_ON);
    localparam int                DRAIN_GAP  = 4;

    class relay_scoreboard;
        logic [ANGLE_W-1:0] angle;
        logic [CTRL_W-1:0]  ctrl;
        logic [COUNT_W-1:0] pulses;
        bit                 running;
        bit                 timer_on;
        bit                 edge_hi;
        bit                 step_lvl;
        bit                 enable_lvl;
        bit                 dir_lvl;
        t_result            pending_q[$];
        int                 errors;

        function new();
            angle      = ANGLE_RESET;
            ctrl       = '0;
            pulses     = '0;
            running    = 1'b0;
            timer_on   = 1'b0;
            edge_hi    = 1'b0;
            step_lvl   = 1'b0;
            enable_lvl = 1'b0;
            dir_lvl    = 1'b0;
            errors     = 0;
        endfunction

        function void load_motor();
            if (ctrl[BIT_MOTOR_ON]) begin
                enable_lvl = 1'b1;
                dir_lvl    = ctrl[BIT_REVERSE];
                pulses     = COUNT_W'((32'(angle) * 5) / 9 + 4);
                running    = 1'b1;
                timer_on   = 1'b1;
            end else begin
                enable_lvl = 1'b0;
                dir_lvl    = 1'b0;
                running    = 1'b0;
                pulses     = '0;
            end
        endfunction

        // returns 0 for the spare opcode and for a tick while the timer is off, else 1
        function bit note_word(logic [1:0] op, logic [CTRL_W-1:0] mask);
            t_result exp_res;
            bit      acted;
            bit      done;
            acted = 1'b1;
            done  = 1'b0;
            case (op)
                OP_SET: begin
                    ctrl = ctrl | mask;
                    load_motor();
                end
                OP_CLEAR: begin
                    ctrl = ctrl & ~mask;
                    load_motor();
                end
                OP_TICK: begin
                    if (!timer_on) begin
                        acted = 1'b0;
                    end else if (pulses != '0) begin
                        step_lvl = !edge_hi;
                        edge_hi  = !edge_hi;
                        if (!edge_hi)
                            pulses = pulses - COUNT_W'(1);
                    end else if (running) begin
                        ctrl     = ctrl & END_MASK;
                        running  = 1'b0;
                        timer_on = 1'b0;
                        done     = 1'b1;
                    end
                end
                default: begin
                    acted = 1'b0;
                end
            endcase
            exp_res.relay_one       = ctrl[BIT_RELAY1];
            exp_res.relay_two       = ctrl[BIT_RELAY2];
            exp_res.motor_enable    = enable_lvl;
            exp_res.motor_direction = dir_lvl;
            exp_res.step_line       = step_lvl;
            exp_res.control_value   = ctrl;
            exp_res.done_report     = done;
            pending_q.push_back(exp_res);
            return acted;
        endfunction

        function void check_field(string name, logic [CTRL_W-1:0] exp_v,
                                  logic [CTRL_W-1:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_res;
            if (pending_q.size() == 0) begin
                $error("unexpected result word: %p", got);
                errors++;
                return;
            end
            exp_res = pending_q.pop_front();
            check_field("relay_one", CTRL_W'(exp_res.relay_one), CTRL_W'(got.relay_one));
            check_field("relay_two", CTRL_W'(exp_res.relay_two), CTRL_W'(got.relay_two));
            check_field("motor_enable", CTRL_W'(exp_res.motor_enable),
                        CTRL_W'(got.motor_enable));
            check_field("motor_direction", CTRL_W'(exp_res.motor_direction),
                        CTRL_W'(got.motor_direction));
            check_field("step_line", CTRL_W'(exp_res.step_line), CTRL_W'(got.step_line));
            check_field("control_value", exp_res.control_value, got.control_value);
            check_field("done_report", CTRL_W'(exp_res.done_report),
                        CTRL_W'(got.done_report));
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [ANGLE_W-1:0] cfg_wdata;

    spr_cmd_if cmd_if ();
    spr_res_if res_if ();

    relay_scoreboard sb;
    int              sent_words;
    int              useful_words;
    bit              steady;

    stepper_pulse_relay_control u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("stepper_pulse_relay_control verification failed");
        $finish;
    end

    always @(negedge i_clk) begin
        res_if.ready <= steady || ($urandom_range(0, 99) >= 20);
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.relay_one       = res_if.relay_one;
            got.relay_two       = res_if.relay_two;
            got.motor_enable    = res_if.motor_enable;
            got.motor_direction = res_if.motor_direction;
            got.step_line       = res_if.step_line;
            got.control_value   = res_if.control_value;
            got.done_report     = res_if.done_report;
            sb.check_result(got);
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [CTRL_W-1:0] mask);
        while (!steady && $urandom_range(0, 99) < 20) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.opcode   <= op;
        cmd_if.bit_mask <= mask;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        if (sb.note_word(op, mask))
            useful_words++;
        sent_words++;
        steady = (sent_words >= 700 && sent_words < 1000);
        @(negedge i_clk);
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_GAP) @(negedge i_clk);
    endtask

    task automatic write_angle(input logic [ANGLE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        sb.angle = value;
    endtask

    task automatic run_phase(input int budget);
        int stop_at;
        int ticks;
        stop_at = useful_words + budget;
        while (useful_words < stop_at) begin
            if ($urandom_range(0, 149) == 0)
                drain();
            if ($urandom_range(0, 9) < 7) begin
                // restart: any write with the motor bit set reloads the count
                if (sb.ctrl[BIT_MOTOR_ON] && $urandom_range(0, 3) == 0)
                    send_word(OP_CLEAR, CTRL_W'($urandom) & ~MOTOR_MASK);
                else
                    send_word(OP_SET, CTRL_W'($urandom) | MOTOR_MASK);
                ticks = 2 * int'(sb.pulses) + 1 + $urandom_range(0, 2);
                for (int k = 0; k < ticks && useful_words < stop_at; k++) begin
                    if ($urandom_range(0, 24) == 0)
                        send_word(2'($urandom_range(0, 3)), CTRL_W'($urandom));
                    else
                        send_word(OP_TICK, CTRL_W'($urandom));
                end
            end else begin
                send_word(2'($urandom_range(0, 3)), CTRL_W'($urandom));
            end
        end
    endtask

    initial begin
        sb              = new();
        sent_words      = 0;
        useful_words    = 0;
        steady          = 1'b0;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        cmd_if.valid    = 1'b0;
        cmd_if.opcode   = OP_SET;
        cmd_if.bit_mask = '0;
        res_if.ready    = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset angle: stopped tick, spare opcode, relays only, start reversed
        send_word(OP_TICK, 8'hFF);
        send_word(OP_SPARE, 8'hFF);
        send_word(OP_SET, 8'h03);
        send_word(OP_SET, 8'h0C);
        send_word(OP_TICK, 8'h00);
        send_word(OP_TICK, 8'hFF);
        send_word(OP_SET, 8'h01);
        drain();

        // zero angle: full move to completion, then stop mid-move
        write_angle('0);
        send_word(OP_SET, MOTOR_MASK);
        repeat (8) send_word(OP_TICK, CTRL_W'($urandom));
        send_word(OP_TICK, CTRL_W'($urandom));
        send_word(OP_TICK, CTRL_W'($urandom));
        send_word(OP_SET, MOTOR_MASK);
        send_word(OP_TICK, CTRL_W'($urandom));
        send_word(OP_CLEAR, MOTOR_MASK);
        send_word(OP_TICK, CTRL_W'($urandom));
        send_word(OP_CLEAR, 8'hFF);
        send_word(OP_SET, 8'h00);
        send_word(OP_CLEAR, 8'h00);
        drain();

        write_angle(16'hFFFF);
        run_phase(60);
        drain();
        write_angle('0);
        run_phase(300);
        drain();
        for (int p = 0; p < 4; p++) begin
            write_angle(ANGLE_W'($urandom_range(1, 60)));
            run_phase(250);
            drain();
        end
        write_angle(ANGLE_RESET);
        run_phase(170);
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("stepper_pulse_relay_control verification clean");
        else
            $display("stepper_pulse_relay_control verification failed");
        $finish;
    end

endmodule

// ===== stepper_pulse_relay_control.f =====
hw/rtl/spr_pkg.sv
hw/rtl/spr_cmd_if.sv
hw/rtl/spr_res_if.sv
hw/rtl/spr_cfg.sv
hw/rtl/spr_core.sv
hw/rtl/stepper_pulse_relay_control.sv
hw/rtl/spr_checker.sv
verif/stepper_pulse_relay_control_tb.sv
